[design/rte_pkg.sv]
// Shared types and constants of the route table engine.
`timescale 1ns / 1ps

package rte_pkg;

    localparam int unsigned PADDR_W = 3;

    localparam logic [1:0] OP_UPDATE     = 2'd0;
    localparam logic [1:0] OP_LOOKUP     = 2'd1;
    localparam logic [1:0] OP_INVALIDATE = 2'd2;
    localparam logic [1:0] OP_NONE       = 2'd3;

    localparam logic [1:0] ST_IGNORED   = 2'd0;
    localparam logic [1:0] ST_INSERTED  = 2'd1;
    localparam logic [1:0] ST_REFRESHED = 2'd2;
    localparam logic [1:0] ST_KEPT      = 2'd3;

    localparam logic        REG_LIFETIME   = 1'b0;
    localparam logic [26:0] LIFETIME_RESET = 27'd60000;
    localparam logic [15:0] RESERVED_DEST  = 16'h0000;
    localparam logic [4:0]  MAX_REPORTS    = 5'd16;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_ms;
        logic [15:0] dest_id;
        logic [31:0] dest_seq;
        logic [7:0]  hops;
        logic [15:0] via_node;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] route_dest;
        logic [15:0] route_next;
        logic [7:0]  route_hops;
        logic [31:0] route_seq;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [15:0] dest;
        logic [31:0] seq;
        logic [7:0]  hops;
        logic [15:0] next;
        logic [31:0] expiry;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMP,
        S_ACT,
        S_INV
    } t_state;

endpackage

[design/route_table_engine_unit.sv]
// Top level of the route table engine.
`timescale 1ns / 1ps
// Route table engine: a table of routes kept in one synchronous memory.
// Command channel: drive i_cmd with start; the command transfers at a clock
// edge where start is high and busy is low.
// Result channel: each result appears on o_res for one cycle with
// o_res_valid high; last marks the final result of a command.
// Configuration: APB-style port, route lifetime at byte address 0; write
// it only while busy is low and no result is outstanding.
// Sequence of each command:
//   ignored update or unknown operation: one result, the cycle after the
//   transfer, busy stays low.
//   update, lookup or invalidate of an unknown route: one result, after
//   the compaction scan and the action state.
//   invalidate of a live route: the action state after compaction, then a
//   scan of the table, one result per invalidated route, at most sixteen,
//   the last as the scan ends.
// Busy falls as the last result appears; the next command may transfer then.
// The memory reads one entry per cycle during each scan.
// Reset clears the live count, so the table starts empty.
// The receiver cannot hold results off; none is ever repeated.

module route_table_engine_unit #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  rte_pkg::t_cmd               i_cmd,
    output rte_pkg::t_res               o_res,
    output logic                        o_res_valid,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rte_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    logic [26:0]     lifetime;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    rte_pkg::t_entry rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    rte_pkg::t_entry wr_data;

    rte_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_lifetime (lifetime)
    );

    rte_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    rte_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cmd       (i_cmd),
        .i_lifetime  (lifetime),
        .o_res       (o_res),
        .o_res_valid (o_res_valid),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

endmodule

[design/rte_mem.sv]
// Route entry memory: one write port, one registered read port.
`timescale 1ns / 1ps

module rte_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output rte_pkg::t_entry o_rd_data,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  rte_pkg::t_entry i_wr_data
);

    rte_pkg::t_entry r_mem [DEPTH];
    rte_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

[design/rte_cfg.sv]
// Configuration register block on the APB-style port.
`timescale 1ns / 1ps

module rte_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rte_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [26:0]                 o_lifetime
);

    logic [26:0] r_lifetime;
    logic        reg_sel;
    logic        wr_xfer;

    assign reg_sel = (paddr[rte_pkg::PADDR_W-1] == rte_pkg::REG_LIFETIME);
    assign wr_xfer = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= rte_pkg::LIFETIME_RESET;
        end else if (wr_xfer && reg_sel) begin
            r_lifetime <= pwdata[26:0];
        end
    end

    assign prdata     = reg_sel ? {5'd0, r_lifetime} : 32'd0;
    assign pready     = 1'b1;
    assign o_lifetime = r_lifetime;

endmodule

[design/rte_ctrl.sv]
// Sequencer: compaction, route update, lookup and invalidate scans over the memory.
`timescale 1ns / 1ps

module rte_ctrl #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned CW    = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  rte_pkg::t_cmd   i_cmd,
    input  logic [26:0]     i_lifetime,
    output rte_pkg::t_res   o_res,
    output logic            o_res_valid,
    output logic            o_rd_en,
    output logic [AW-1:0]   o_rd_addr,
    input  rte_pkg::t_entry i_rd_data,
    output logic            o_wr_en,
    output logic [AW-1:0]   o_wr_addr,
    output rte_pkg::t_entry o_wr_data
);

    rte_pkg::t_state r_state, n_state;
    rte_pkg::t_cmd   r_cmd, n_cmd;
    logic [31:0]     r_expiry, n_expiry;
    logic [CW-1:0]   r_live, n_live;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_wr, n_wr;
    logic            r_rd_vld, n_rd_vld;
    logic [AW-1:0]   r_rd_idx, n_rd_idx;
    logic            r_hit, n_hit;
    logic [AW-1:0]   r_idx, n_idx;
    rte_pkg::t_entry r_hit_ent, n_hit_ent;
    logic            r_pend, n_pend;
    rte_pkg::t_entry r_pend_ent, n_pend_ent;
    logic [4:0]      r_nrep, n_nrep;
    rte_pkg::t_res   r_res, n_res;
    logic            r_res_vld, n_res_vld;

    logic            accept;
    logic            ignored;
    logic            issue;
    logic            scan_end;
    logic [31:0]     seq_diff;

    function automatic rte_pkg::t_res route_res(rte_pkg::t_entry e, logic last);
        rte_pkg::t_res r;
        r            = '0;
        r.found      = 1'b1;
        r.route_dest = e.dest;
        r.route_next = e.next;
        r.route_hops = e.hops;
        r.route_seq  = e.seq;
        r.last       = last;
        return r;
    endfunction

    assign accept   = i_start && (r_state == rte_pkg::S_IDLE);
    assign ignored  = (i_cmd.operation == rte_pkg::OP_NONE) ||
                      ((i_cmd.operation == rte_pkg::OP_UPDATE) &&
                       (i_cmd.dest_id == rte_pkg::RESERVED_DEST));
    assign issue    = (r_ptr < r_live);
    assign scan_end = !issue && !r_rd_vld;
    assign seq_diff = r_cmd.dest_seq - r_hit_ent.seq;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rte_pkg::S_IDLE: begin
                if (accept && !ignored) begin
                    n_state = rte_pkg::S_COMP;
                end
            end
            rte_pkg::S_COMP: begin
                if (scan_end) begin
                    n_state = rte_pkg::S_ACT;
                end
            end
            rte_pkg::S_ACT: begin
                if ((r_cmd.operation == rte_pkg::OP_INVALIDATE) && r_hit) begin
                    n_state = rte_pkg::S_INV;
                end else begin
                    n_state = rte_pkg::S_IDLE;
                end
            end
            rte_pkg::S_INV: begin
                if (scan_end) begin
                    n_state = rte_pkg::S_IDLE;
                end
            end
            default: n_state = rte_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        rte_pkg::t_entry dead_ent;
        dead_ent   = i_rd_data;
        dead_ent.expiry = '0;
        n_cmd      = r_cmd;
        n_expiry   = r_expiry;
        n_live     = r_live;
        n_ptr      = r_ptr;
        n_wr       = r_wr;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_hit      = r_hit;
        n_idx      = r_idx;
        n_hit_ent  = r_hit_ent;
        n_pend     = r_pend;
        n_pend_ent = r_pend_ent;
        n_nrep     = r_nrep;
        n_res      = '0;
        n_res_vld  = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_ptr[AW-1:0];
        o_wr_en    = 1'b0;
        o_wr_addr  = r_wr[AW-1:0];
        o_wr_data  = i_rd_data;
        unique case (r_state)
            rte_pkg::S_IDLE: begin
                if (accept) begin
                    if (ignored) begin
                        n_res.last = 1'b1;
                        n_res_vld  = 1'b1;
                    end else begin
                        n_cmd    = i_cmd;
                        n_expiry = i_cmd.now_ms + {5'd0, i_lifetime};
                        n_ptr    = '0;
                        n_wr     = '0;
                        n_hit    = 1'b0;
                    end
                end
            end
            rte_pkg::S_COMP: begin
                if (issue) begin
                    o_rd_en  = 1'b1;
                    n_ptr    = r_ptr + 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld && (i_rd_data.expiry > r_cmd.now_ms)) begin
                    o_wr_en = 1'b1;
                    n_wr    = r_wr + 1'b1;
                    if (!r_hit && (i_rd_data.dest == r_cmd.dest_id)) begin
                        n_hit     = 1'b1;
                        n_idx     = r_wr[AW-1:0];
                        n_hit_ent = i_rd_data;
                    end
                end
                if (scan_end) begin
                    n_live = r_wr;
                end
            end
            rte_pkg::S_ACT: begin
                unique case (r_cmd.operation)
                    rte_pkg::OP_UPDATE: begin
                        n_res_vld        = 1'b1;
                        n_res.last       = 1'b1;
                        o_wr_data.dest   = r_cmd.dest_id;
                        o_wr_data.seq    = r_cmd.dest_seq;
                        o_wr_data.hops   = r_cmd.hops;
                        o_wr_data.next   = r_cmd.via_node;
                        o_wr_data.expiry = r_expiry;
                        if (!r_hit) begin
                            o_wr_en      = 1'b1;
                            n_res.status = rte_pkg::ST_INSERTED;
                            if (r_live == CW'(DEPTH)) begin
                                o_wr_addr = '0;
                                n_live    = CW'(1);
                            end else begin
                                o_wr_addr = r_live[AW-1:0];
                                n_live    = r_live + 1'b1;
                            end
                        end else if (!seq_diff[31]) begin
                            o_wr_en      = 1'b1;
                            o_wr_addr    = r_idx;
                            n_res.status = rte_pkg::ST_REFRESHED;
                        end else begin
                            n_res.status = rte_pkg::ST_KEPT;
                        end
                    end
                    rte_pkg::OP_LOOKUP: begin
                        n_res_vld = 1'b1;
                        if (r_hit) begin
                            n_res = route_res(r_hit_ent, 1'b1);
                        end else begin
                            n_res.last = 1'b1;
                        end
                    end
                    rte_pkg::OP_INVALIDATE: begin
                        if (!r_hit) begin
                            n_res_vld  = 1'b1;
                            n_res.last = 1'b1;
                        end else begin
                            n_ptr  = '0;
                            n_pend = 1'b0;
                            n_nrep = '0;
                        end
                    end
                    default: begin
                        n_res_vld  = 1'b1;
                        n_res.last = 1'b1;
                    end
                endcase
            end
            rte_pkg::S_INV: begin
                if (issue) begin
                    o_rd_en  = 1'b1;
                    n_ptr    = r_ptr + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_ptr[AW-1:0];
                end
                if (r_rd_vld && (i_rd_data.next == r_hit_ent.next) &&
                    (i_rd_data.expiry != 32'd0)) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_rd_idx;
                    o_wr_data = dead_ent;
                    if (r_nrep < rte_pkg::MAX_REPORTS) begin
                        n_nrep     = r_nrep + 1'b1;
                        n_pend     = 1'b1;
                        n_pend_ent = i_rd_data;
                        if (r_pend) begin
                            n_res     = route_res(r_pend_ent, 1'b0);
                            n_res_vld = 1'b1;
                        end
                    end
                end
                if (scan_end) begin
                    n_res_vld = 1'b1;
                    if (r_pend) begin
                        n_res = route_res(r_pend_ent, 1'b1);
                    end else begin
                        n_res.last = 1'b1;
                    end
                end
            end
            default: begin
                n_res_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rte_pkg::S_IDLE;
            r_live    <= '0;
            r_rd_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_rd_vld  <= n_rd_vld;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_expiry   <= n_expiry;
        r_ptr      <= n_ptr;
        r_wr       <= n_wr;
        r_rd_idx   <= n_rd_idx;
        r_hit      <= n_hit;
        r_idx      <= n_idx;
        r_hit_ent  <= n_hit_ent;
        r_pend     <= n_pend;
        r_pend_ent <= n_pend_ent;
        r_nrep     <= n_nrep;
        r_res      <= n_res;
    end

    assign o_busy      = (r_state != rte_pkg::S_IDLE);
    assign o_res       = r_res;
    assign o_res_valid = r_res_vld;

endmodule
